// ----- design/vku_pkg.sv -----
// Shared types and constants of the vehicle kinematic update unit.
package vku_pkg;

  localparam int unsigned DT_BITS    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [1:0] MODE_EULER     = 2'd0;
  localparam logic [1:0] MODE_BALLISTIC = 2'd1;
  localparam logic [1:0] MODE_TRAPEZOID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENFORCE_LIMIT = 2'd3;

  localparam logic [1:0] CLAMP_NONE     = 2'd0;
  localparam logic [1:0] CLAMP_LIMIT    = 2'd1;
  localparam logic [1:0] CLAMP_EXPECTED = 2'd2;
  localparam logic [1:0] CLAMP_ZERO     = 2'd3;

  localparam logic [1:0]  RST_UPDATE_MODE   = MODE_EULER;
  localparam logic [15:0] RST_STEP_TIME     = 16'd6554;
  localparam logic [23:0] RST_INV_STEP_TIME = 24'd2560;
  localparam logic        RST_ENFORCE_LIMIT = 1'b0;

  typedef struct packed {
    logic [31:0]        position;
    logic [15:0]        speed;
    logic signed [15:0] prev_accel;
    logic signed [15:0] model_accel;
    logic [15:0]        expected_speed;
    logic [15:0]        speed_limit_here;
  } vku_in_t;

  typedef struct packed {
    logic [31:0]        new_position;
    logic [15:0]        new_speed;
    logic signed [15:0] new_accel;
    logic [1:0]         clamp_code;
  } vku_out_t;

endpackage

// ----- design/vku_chan_if.sv -----
// Valid/ready stream channel carrying one payload beat.
interface vku_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/vehicle_kinematic_update_unit.sv -----
// Vehicle kinematic update unit: seven-stage pipeline that advances one vehicle per beat.
// Accepts one vehicle per clock cycle; throughput is one item per cycle whenever the output
// side takes beats, and a stalled output fills empty stages before holding the input. The
// stages follow the chain of the speed multiply, the acceleration multiply by the inverse
// step time and the two multiplies of a*dt*dt for the trapezoidal position, each followed
// by a register. Configuration must be written through the plain write port only while no
// vehicle is in flight; the block does not enforce this. Update mode 3 acts as Euler.
// Acceleration saturates to 16 bits signed and position to 32 bits unsigned.
module vehicle_kinematic_update_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vku_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vku_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  vku_chan_if.sink                       in_i,
  vku_chan_if.source                     out_o
);
  import vku_pkg::*;

  localparam int unsigned NS = 7;

  localparam logic signed [33:0] V_HALF_E  = 34'sd1 <<< (DT_BITS - 1);
  localparam logic signed [33:0] V_HALF_T  = 34'sd1 <<< DT_BITS;
  localparam logic signed [41:0] A_HALF    = 42'sd1 <<< (FRAC_BITS - 1);
  localparam logic [33:0]        X_HALF_E  = 34'd1 << (DT_BITS - 1);
  localparam logic [33:0]        X_HALF_B  = 34'd1 << DT_BITS;
  localparam logic signed [51:0] X_HALF_T  = 52'sd1 <<< (2 * DT_BITS);
  localparam logic signed [41:0] A_MAX     = 42'sd32767;
  localparam logic signed [41:0] A_MIN     = -42'sd32768;
  localparam logic signed [34:0] X_MAX     = 35'sh0_FFFF_FFFF;

  // Configuration registers
  logic [1:0]  mode_q;
  logic [15:0] dt_q;
  logic [23:0] inv_dt_q;
  logic        enf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_UPDATE_MODE;
      dt_q     <= RST_STEP_TIME;
      inv_dt_q <= RST_INV_STEP_TIME;
      enf_q    <= RST_ENFORCE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UPDATE_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_STEP_TIME:     dt_q     <= cfg_wdata_i[15:0];
        REG_INV_STEP_TIME: inv_dt_q <= cfg_wdata_i[23:0];
        REG_ENFORCE_LIMIT: enf_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic               trap, ball;
  logic signed [16:0] dt_s;
  assign trap = (mode_q == MODE_TRAPEZOID);
  assign ball = (mode_q == MODE_BALLISTIC);
  assign dt_s = $signed({1'b0, dt_q});

  // Stage valid bits and per-stage advance; an empty stage may always load
  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: speed increment product
  logic [31:0]        s1_pos_q;
  logic [15:0]        s1_v0_q, s1_vexp_q, s1_vlim_q;
  logic signed [15:0] s1_ma_q;
  logic signed [33:0] s1_prod_q, s1_prod_d;
  logic signed [16:0] acc_sum;

  always_comb begin
    if (trap) begin
      acc_sum = $signed({in_i.data.model_accel[15], in_i.data.model_accel})
              + $signed({in_i.data.prev_accel[15], in_i.data.prev_accel});
    end else begin
      acc_sum = $signed({in_i.data.model_accel[15], in_i.data.model_accel});
    end
    s1_prod_d = acc_sum * dt_s;
  end

  // Stage 2: integrate speed and apply the clamps
  logic [31:0]        s2_pos_q;
  logic [15:0]        s2_v0_q, s2_vnew_q, s2_vnew_d;
  logic signed [15:0] s2_ma_q;
  logic [1:0]         s2_code_q, s2_code_d;
  logic signed [16:0] s2_diff_q, s2_diff_d;
  logic signed [33:0] v_rnd;
  logic signed [18:0] v_int, v_lim1, vlim_s, vexp_s;
  logic               lim_hit;
  logic [15:0]        target;

  always_comb begin
    if (trap) v_rnd = (s1_prod_q + V_HALF_T) >>> (DT_BITS + 1);
    else      v_rnd = (s1_prod_q + V_HALF_E) >>> DT_BITS;
    v_int   = $signed({3'b000, s1_v0_q}) + v_rnd[18:0];
    vlim_s  = $signed({3'b000, s1_vlim_q});
    vexp_s  = $signed({3'b000, s1_vexp_q});
    lim_hit = enf_q && (v_int > vlim_s);
    v_lim1  = lim_hit ? vlim_s : v_int;
    if (v_lim1 > vexp_s) begin
      s2_code_d = CLAMP_EXPECTED;
      target    = s1_vexp_q;
    end else if (v_lim1 < 19'sd0) begin
      s2_code_d = CLAMP_ZERO;
      target    = '0;
    end else if (lim_hit) begin
      s2_code_d = CLAMP_LIMIT;
      target    = s1_vlim_q;
    end else begin
      s2_code_d = CLAMP_NONE;
      target    = v_lim1[15:0];
    end
    s2_vnew_d = target;
    s2_diff_d = $signed({1'b0, target}) - $signed({1'b0, s1_v0_q});
  end

  // Stage 3: acceleration product with the inverse step time
  logic [31:0]        s3_pos_q;
  logic [15:0]        s3_v0_q, s3_vnew_q;
  logic signed [15:0] s3_ma_q;
  logic [1:0]         s3_code_q;
  logic signed [41:0] s3_prod_q, s3_prod_d;

  assign s3_prod_d = s2_diff_q * $signed({1'b0, inv_dt_q});

  // Stage 4: round and saturate the acceleration, or keep the model acceleration when unclamped
  logic [31:0]        s4_pos_q;
  logic [15:0]        s4_v0_q, s4_vnew_q;
  logic [1:0]         s4_code_q;
  logic signed [15:0] s4_accel_q, s4_accel_d;
  logic signed [41:0] a_rnd;

  always_comb begin
    a_rnd = (s3_prod_q + A_HALF) >>> FRAC_BITS;
    if (s3_code_q == CLAMP_NONE) s4_accel_d = s3_ma_q;
    else if (a_rnd > A_MAX)      s4_accel_d = 16'sh7FFF;
    else if (a_rnd < A_MIN)      s4_accel_d = -16'sh8000;
    else                         s4_accel_d = a_rnd[15:0];
  end

  // Stage 5: position products
  logic [31:0]        s5_pos_q;
  logic [15:0]        s5_vnew_q;
  logic signed [15:0] s5_accel_q;
  logic [1:0]         s5_code_q;
  logic [32:0]        s5_pm_q, s5_pm_d;
  logic [31:0]        s5_p1_q, s5_p1_d;
  logic signed [32:0] s5_ad_q, s5_ad_d;
  logic [16:0]        v_sum;

  always_comb begin
    v_sum   = ball ? ({1'b0, s4_v0_q} + {1'b0, s4_vnew_q}) : {1'b0, s4_vnew_q};
    s5_pm_d = v_sum * {1'b0, dt_q};
    s5_p1_d = s4_v0_q * dt_q;
    s5_ad_d = s4_accel_q * dt_s;
  end

  // Stage 6: second step-time product of the trapezoidal term
  logic [31:0]        s6_pos_q;
  logic [15:0]        s6_vnew_q;
  logic signed [15:0] s6_accel_q;
  logic [1:0]         s6_code_q;
  logic [32:0]        s6_pm_q;
  logic [31:0]        s6_p1_q;
  logic signed [49:0] s6_add_q, s6_add_d;

  assign s6_add_d = s5_ad_q * dt_s;

  // Stage 7: sum, round and saturate the position into the output register
  vku_out_t           out_q, out_d;
  logic signed [51:0] x_trap;
  logic [33:0]        x_lin;
  logic signed [34:0] x_delta, x_sum;

  always_comb begin
    x_trap = $signed({3'b000, s6_p1_q, 17'd0}) + 52'(s6_add_q) + X_HALF_T;
    x_trap = x_trap >>> (2 * DT_BITS + 1);
    if (ball) x_lin = ({1'b0, s6_pm_q} + X_HALF_B) >> (DT_BITS + 1);
    else      x_lin = ({1'b0, s6_pm_q} + X_HALF_E) >> DT_BITS;
    x_delta = trap ? x_trap[34:0] : $signed({1'b0, x_lin});
    x_sum   = $signed({3'b000, s6_pos_q}) + x_delta;
    if (x_sum < 35'sd0)      out_d.new_position = '0;
    else if (x_sum > X_MAX)  out_d.new_position = 32'hFFFF_FFFF;
    else                     out_d.new_position = x_sum[31:0];
    out_d.new_speed  = s6_vnew_q;
    out_d.new_accel  = s6_accel_q;
    out_d.clamp_code = s6_code_q;
  end

  // Payload registers: load when the stage advances and the upstream beat is valid
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_i.valid) begin
      s1_pos_q  <= in_i.data.position;
      s1_v0_q   <= in_i.data.speed;
      s1_ma_q   <= in_i.data.model_accel;
      s1_vexp_q <= in_i.data.expected_speed;
      s1_vlim_q <= in_i.data.speed_limit_here;
      s1_prod_q <= s1_prod_d;
    end
    if (adv[1] && vld_q[0]) begin
      s2_pos_q  <= s1_pos_q;
      s2_v0_q   <= s1_v0_q;
      s2_ma_q   <= s1_ma_q;
      s2_vnew_q <= s2_vnew_d;
      s2_code_q <= s2_code_d;
      s2_diff_q <= s2_diff_d;
    end
    if (adv[2] && vld_q[1]) begin
      s3_pos_q  <= s2_pos_q;
      s3_v0_q   <= s2_v0_q;
      s3_vnew_q <= s2_vnew_q;
      s3_ma_q   <= s2_ma_q;
      s3_code_q <= s2_code_q;
      s3_prod_q <= s3_prod_d;
    end
    if (adv[3] && vld_q[2]) begin
      s4_pos_q   <= s3_pos_q;
      s4_v0_q    <= s3_v0_q;
      s4_vnew_q  <= s3_vnew_q;
      s4_code_q  <= s3_code_q;
      s4_accel_q <= s4_accel_d;
    end
    if (adv[4] && vld_q[3]) begin
      s5_pos_q   <= s4_pos_q;
      s5_vnew_q  <= s4_vnew_q;
      s5_accel_q <= s4_accel_q;
      s5_code_q  <= s4_code_q;
      s5_pm_q    <= s5_pm_d;
      s5_p1_q    <= s5_p1_d;
      s5_ad_q    <= s5_ad_d;
    end
    if (adv[5] && vld_q[4]) begin
      s6_pos_q   <= s5_pos_q;
      s6_vnew_q  <= s5_vnew_q;
      s6_accel_q <= s5_accel_q;
      s6_code_q  <= s5_code_q;
      s6_pm_q    <= s5_pm_q;
      s6_p1_q    <= s5_p1_q;
      s6_add_q   <= s6_add_d;
    end
    if (adv[6] && vld_q[5]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = vld_q[NS-1];
  assign out_o.data  = out_q;

  // An accepted beat always occupies the first stage next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted beat missing from first stage");

  // A zero-floor clamp leaves zero speed
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && (s2_code_q == CLAMP_ZERO) |-> (s2_vnew_q == 16'd0))
    else $error("zero floor clamp with nonzero speed");

  // Braking to zero never yields a positive acceleration
  a_zero_accel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && (s4_code_q == CLAMP_ZERO) |-> (s4_accel_q <= 16'sd0))
    else $error("zero floor clamp with positive acceleration");

  // A full, stalled output blocks the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while pipeline is full and stalled");

endmodule
